@@ design/mdse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdse_pkg: shared types and codes
// Phase encoding, status codes, register indexes and the result item layout
// used by the segment extractor core, its output queue and the top level.
// ----------------------------------------------------------------------------
package mdse_pkg;

	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_START_MARKER = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_END_MARKER   = 1'd1;

	// Output queue depth; an item may push two results
	localparam int OutDepth = 4;
	localparam int OutPtrW  = $clog2(OutDepth);
	localparam int OutCntW  = $clog2(OutDepth + 1);

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_SEG   = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NO_START  = 2'd1,
		ST_NO_END    = 2'd2,
		ST_EMPTY_SEG = 2'd3
	} status_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		status_t    status;
	} res_t;

	// Results produced by one accepted item
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

@@ design/mdse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdse_core: marker search and segment state
// Holds the byte window and message phase; turns each accepted item into
// zero, one or two result items combinationally.
// ----------------------------------------------------------------------------
module mdse_core import mdse_pkg::*; #(
	parameter int MARKER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                msg_end,
	output push_t               push
);

	localparam int WinW  = 8 * MARKER_BYTES;
	localparam int FillW = $clog2(MARKER_BYTES + 1);
	localparam logic [FillW-1:0] FillFull = FillW'(MARKER_BYTES);

	logic [CfgDataW-1:0] start_marker_q, end_marker_q;
	phase_t              phase_q, phase_d;
	logic [WinW-1:0]     win_q, win_d;
	logic [FillW-1:0]    fill_q, fill_d;
	logic                sp_q, sp_d, ep_q, ep_d;
	logic [2:0]          cnt_q, cnt_d;

	logic [WinW-1:0] start_w, end_w;
	logic            emit;
	logic [7:0]      emit_byte;
	status_t         st;
	res_t            pay_r, st_r;

	assign start_w = WinW'(start_marker_q);
	assign end_w   = WinW'(end_marker_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			end_marker_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_START_MARKER) begin
				start_marker_q <= cfg_data;
			end else if (cfg_index == REG_END_MARKER) begin
				end_marker_q <= cfg_data;
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		win_d     = win_q;
		fill_d    = fill_q;
		sp_d      = sp_q;
		ep_d      = ep_q;
		cnt_d     = cnt_q;
		emit      = 1'b0;
		emit_byte = win_q[WinW-1 -: 8];
		st        = ST_FOUND;

		if (phase_d == PH_START) begin
			if (sp_d) begin
				phase_d = PH_SEG;
				win_d   = '0;
				fill_d  = '0;
				sp_d    = 1'b0;
			end else begin
				win_d = (win_d << 8) | WinW'(in_byte);
				if (fill_d < FillFull) fill_d = fill_d + 1'b1;
				if (fill_d == FillFull && win_d == start_w) sp_d = 1'b1;
			end
		end

		if (phase_d == PH_SEG) begin
			if (ep_d) begin
				phase_d = PH_DONE;
			end else begin
				if (fill_d == FillFull) begin
					emit      = 1'b1;
					emit_byte = win_d[WinW-1 -: 8];
					if (cnt_d != 3'd7) cnt_d = cnt_d + 1'b1;
				end
				win_d = (win_d << 8) | WinW'(in_byte);
				if (fill_d < FillFull) fill_d = fill_d + 1'b1;
				if (fill_d == FillFull && win_d == end_w) ep_d = 1'b1;
			end
		end

		unique case (phase_d)
			PH_START: st = ST_NO_START;
			PH_SEG:   st = ST_NO_END;
			default:  st = (cnt_d != 3'd0) ? ST_FOUND : ST_EMPTY_SEG;
		endcase

		// Message done: back to reset state
		if (msg_end) begin
			phase_d = PH_START;
			win_d   = '0;
			fill_d  = '0;
			sp_d    = 1'b0;
			ep_d    = 1'b0;
			cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			win_q   <= '0;
			fill_q  <= '0;
			sp_q    <= 1'b0;
			ep_q    <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			win_q   <= win_d;
			fill_q  <= fill_d;
			sp_q    <= sp_d;
			ep_q    <= ep_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		pay_r.kind   = KIND_PAYLOAD;
		pay_r.data   = emit_byte;
		pay_r.status = ST_FOUND;
		st_r.kind    = KIND_STATUS;
		st_r.data    = 8'd0;
		st_r.status  = st;
		push.r0      = emit ? pay_r : st_r;
		push.r1      = st_r;
		push.num     = accept ? ({1'b0, emit} + {1'b0, msg_end}) : 2'd0;
	end

endmodule

@@ design/mdse_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdse_outq: result item queue
// Small queue taking up to two results per cycle and releasing one per
// cycle while out_ready is high; ready to the core with room for two.
// ----------------------------------------------------------------------------
module mdse_outq import mdse_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t               mem [OutDepth];
	logic [OutPtrW-1:0] wr_q, rd_q;
	logic [OutCntW-1:0] cnt_q;
	logic               pop;
	logic [OutPtrW-1:0] wr_nxt;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= OutCntW'(OutDepth - 2));
	assign wr_nxt    = wr_q + 1'b1;
	assign out_res   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) mem[wr_q] <= push.r0;
		if (push.num == 2'd2) mem[wr_nxt] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OutPtrW'(push.num);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + OutCntW'(push.num) - OutCntW'(pop);
		end
	end

endmodule

@@ design/marker_delimited_segment_extract_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_delimited_segment_extract_unit: start/end marker payload extractor
// Streams one message in byte by byte, finds the start marker and the first
// end marker after it, and streams out the bytes between them.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel: one message byte per item, s_tlast on the final byte.
//  - m_* channel: m_tuser = 0 is a payload byte, m_tuser = 1 the single
//    status item that closes each message (found, no start, no end, empty).
//    Payload bytes seen before a failure status are to be dropped.
//  - Config: cfg_we writes start (index 0) or end (index 1) marker; only
//    while the block is idle. Markers are the low 8*MARKER_BYTES bits,
//    first byte most significant.
//  - Results: each is registered in a 4-entry queue before it reaches m_*.
//  - Throughput: one item per cycle while s_tready is high; the marker
//    compare against the byte window is combinational. A final byte may
//    yield payload + status, drained one per cycle while m_tready is high.
//  - s_tready is high while the queue has room for two results, so the
//    block keeps taking items while a result waits; a stalled m_tready
//    fills the queue and then drops s_tready.
//  - Reset clears markers to zero and returns to searching for a start.
// ----------------------------------------------------------------------------
module marker_delimited_segment_extract_unit import mdse_pkg::*; #(
	parameter int MARKER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	// input bytes
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] in_byte
	input  logic                s_tlast,   // msg_end
	// results
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // [7:0] out_byte, [9:8] status, rest 0
	output logic                m_tuser    // result_kind
);

	logic  accept;
	push_t push;
	res_t  out_res;

	// Item taken when the queue can hold both possible results
	assign accept = s_tvalid && s_tready;

	mdse_core #(
		.MARKER_BYTES(MARKER_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.in_byte  (s_tdata),
		.msg_end  (s_tlast),
		.push     (push)
	);

	mdse_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {6'd0, out_res.status, out_res.data};
	assign m_tuser = out_res.kind;

endmodule

@@ tb/segment_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_result_checker: result predictor and comparator for the extractor
// Watches the configuration port and both stream channels, predicts the
// payload and status items of each accepted message byte, and compares every
// accepted result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_result_checker import mdse_pkg::*; #(
	parameter int MARKER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] in_byte
	input  logic                s_tlast,   // msg_end
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [15:0]         m_tdata,   // [7:0] out_byte, [9:8] status, rest 0
	input  logic                m_tuser,   // result_kind
	output int                  errors,
	output int                  outstanding
);

	localparam int WinW = 8 * MARKER_BYTES;

	logic [31:0]     start_mark;
	logic [31:0]     end_mark;
	phase_t          phase;
	logic [WinW-1:0] recent_bytes;
	int              fill;
	logic            start_seen;
	logic            end_seen;
	logic [2:0]      emitted;
	res_t            expected_results[$];
	res_t            want;

	task automatic clear_message();
		phase        = PH_START;
		recent_bytes = '0;
		fill         = 0;
		start_seen   = 1'b0;
		end_seen     = 1'b0;
		emitted      = 3'd0;
	endtask

	function automatic void shift_in(input logic [7:0] b);
		recent_bytes = WinW'({recent_bytes, b});
		if (fill < MARKER_BYTES)
			fill++;
	endfunction

	// marker bytes above the register are zero for wide markers
	function automatic logic window_hit(input logic [31:0] mark);
		return fill >= MARKER_BYTES && recent_bytes == WinW'(mark);
	endfunction

	task automatic extract_step(input logic [7:0] b, input logic last);
		res_t r;
		if (phase == PH_START) begin
			if (start_seen) begin
				phase        = PH_SEG;
				recent_bytes = '0;
				fill         = 0;
				start_seen   = 1'b0;
			end else begin
				shift_in(b);
				if (window_hit(start_mark))
					start_seen = 1'b1;
			end
		end
		if (phase == PH_SEG) begin
			if (end_seen) begin
				phase = PH_DONE;
			end else begin
				if (fill >= MARKER_BYTES) begin
					r.kind   = KIND_PAYLOAD;
					r.data   = recent_bytes[WinW-1 -: 8];
					r.status = ST_FOUND;
					expected_results.push_back(r);
					if (emitted != 3'd7)
						emitted++;
				end
				shift_in(b);
				if (window_hit(end_mark))
					end_seen = 1'b1;
			end
		end
		if (last) begin
			r.kind = KIND_STATUS;
			r.data = 8'd0;
			case (phase)
				PH_START: r.status = ST_NO_START;
				PH_SEG:   r.status = ST_NO_END;
				default:  r.status = (emitted != 3'd0) ? ST_FOUND : ST_EMPTY_SEG;
			endcase
			expected_results.push_back(r);
			clear_message();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark = '0;
			end_mark   = '0;
			clear_message();
			expected_results.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			// results out are from earlier items, so compare before predicting
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: tuser %0b tdata %h", m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
						errors++;
					end
					if (m_tdata[7:0] !== want.data) begin
						$error("out_byte: expected %h, actual %h", want.data, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[9:8] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[9:8]);
						errors++;
					end
					if (m_tdata[15:10] !== 6'd0) begin
						$error("tdata padding: expected 0, actual %h", m_tdata[15:10]);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_START_MARKER)
					start_mark = cfg_data;
				else if (cfg_index == REG_END_MARKER)
					end_mark = cfg_data;
			end
			if (s_tvalid && s_tready)
				extract_step(s_tdata, s_tlast);
			outstanding = expected_results.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the marker delimited segment extractor
// Sends directed and random messages under several marker settings with
// bursty input and a stalling output side, including two long output
// hold-offs that back the block up; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import mdse_pkg::*;

	localparam int MARKER_BYTES = 4;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_START_MARKER;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = 8'd0;   // [7:0] in_byte
	logic                s_tlast   = 1'b0;   // msg_end
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [15:0]         m_tdata;            // [7:0] out_byte, [9:8] status, rest 0
	logic                m_tuser;            // result_kind

	int errors;
	int outstanding;

	// bytes of the message being built, current markers, sender burst state
	logic [7:0]  msg_bytes[$];
	logic [31:0] cur_start;
	logic [31:0] cur_end;
	int          burst_left   = 0;
	// length of the message sent last
	int          last_msg_len = 0;
	// long output hold-offs asked by the stimulus, served by the receiver
	int          hold_reqs    = 0;

	always #5 clk = ~clk;

	marker_delimited_segment_extract_unit #(
		.MARKER_BYTES(MARKER_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	segment_result_checker #(
		.MARKER_BYTES(MARKER_BYTES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.errors     (errors),
		.outstanding(outstanding)
	);

	// One item on the input channel. Starts on a falling edge, returns at the
	// rising edge that accepted it; valid stays high into the next item
	// unless a gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_msg();
		last_msg_len = msg_bytes.size();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	// marker goes out first byte first; bytes above the register are zero
	task automatic add_marker(input logic [31:0] mark);
		logic [63:0] wide;
		wide = {32'd0, mark};
		for (int i = MARKER_BYTES - 1; i >= 0; i--)
			msg_bytes.push_back(wide[8*i +: 8]);
	endtask

	// filler bytes, half of them marker bytes so partial matches show up
	task automatic add_noise(input int n);
		int sel;
		int pos;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 3);
			pos = $urandom_range(0, 3);
			if (sel == 2)
				msg_bytes.push_back(cur_start[8*pos +: 8]);
			else if (sel == 3)
				msg_bytes.push_back(cur_end[8*pos +: 8]);
			else
				msg_bytes.push_back(8'($urandom));
		end
	endtask

	// Let every expected result drain, wait out any item that produced
	// nothing, then rewrite both markers.
	task automatic set_markers(input logic [31:0] st, input logic [31:0] en);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_MARKER;
		cfg_data  <= st;
		@(negedge clk);
		cfg_index <= REG_END_MARKER;
		cfg_data  <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_start = st;
		cur_end   = en;
	endtask

	task automatic random_msg();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			// well formed: prefix, start, payload, end, tail
			add_noise($urandom_range(0, 4));
			add_marker(cur_start);
			add_noise($urandom_range(0, 9));
			add_marker(cur_end);
			add_noise($urandom_range(0, 3));
		end else if (kind == 7) begin
			// start marker only
			add_noise($urandom_range(0, 3));
			add_marker(cur_start);
			add_noise($urandom_range(0, 6));
		end else if (kind == 8) begin
			add_noise($urandom_range(1, 12));
		end else begin
			// end marker right behind the start marker
			add_marker(cur_start);
			add_marker(cur_end);
			add_noise($urandom_range(0, 2));
		end
		send_msg();
	endtask

	// Receiver: redraws its ready mode periodically; a requested hold-off
	// keeps m_tready low while the sender keeps going.
	initial begin : receiver
		int cyc    = 0;
		int mode   = 0;
		int served = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs > served) begin
				served++;
				m_tready <= 1'b0;
				repeat (80) @(negedge clk);
			end else begin
				if (cyc % 50 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 3) != 0);
					2:       m_tready <= ($urandom_range(0, 2) == 0);
					default: m_tready <= (cyc % 5 != 0);
				endcase
				cyc++;
			end
		end
	end

	initial begin : stimulus
		int phase_bytes;
		logic [31:0] st;
		logic [31:0] en;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		set_markers(32'h00FF_A55A, 32'hFF00_5AA5);
		// one-byte message, no start marker
		msg_bytes.push_back(8'h00);
		send_msg();
		// start marker on the final byte does not count
		add_marker(cur_start);
		send_msg();
		// start marker confirmed by the final byte: no end marker
		add_marker(cur_start);
		msg_bytes.push_back(8'hFF);
		send_msg();
		// end marker directly after start marker: empty segment
		add_marker(cur_start);
		add_marker(cur_end);
		msg_bytes.push_back(8'h5A);
		send_msg();
		// payload at both byte extremes, found
		add_marker(cur_start);
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(8'hFF);
		add_marker(cur_end);
		msg_bytes.push_back(8'h81);
		send_msg();

		// random part, marker settings per phase, extremes among them
		for (int p = 0; p < 6; p++) begin
			case (p)
				1:       begin st = 32'h0000_0000; en = 32'hFFFF_FFFF; end
				2:       begin st = 32'hFFFF_FFFF; en = 32'h0000_0000; end
				3:       begin st = $urandom;      en = st;            end
				default: begin st = $urandom;      en = $urandom;      end
			endcase
			set_markers(st, en);
			if (p == 1 || p == 4)
				hold_reqs++;
			phase_bytes = 0;
			while (phase_bytes < 65) begin
				random_msg();
				phase_bytes = phase_bytes + last_msg_len;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ marker_delimited_segment_extract_unit.f @@
design/mdse_pkg.sv
design/mdse_core.sv
design/mdse_outq.sv
design/marker_delimited_segment_extract_unit.sv
tb/segment_result_checker.sv
tb/tb_top.sv
